FILE: rtl/core/assert_macros.svh
// Assertion helpers; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/cdq_pkg.sv
package cdq_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;
    localparam int CHAR_W = 8;
    localparam int OP_W   = 3;
    localparam int TOT_W  = 7;

    localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'h7A;
    localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REPORT     = 3'd4
    } t_op;

    // request held in the input register
    typedef struct packed {
        logic              vld;
        t_op               op;
        logic [CHAR_W-1:0] chr;
    } t_req;

    // outcome of the ring step, registered beside the read data
    typedef struct packed {
        logic              vld;
        logic              push_ok;
        logic              pop_ok;
        logic              empty;
        logic              full;
        logic [CHAR_W-1:0] chr;
    } t_ring_res;

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return (c >= LOWER_FIRST) && (c <= LOWER_LAST);
    endfunction

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= UPPER_FIRST) && (c <= UPPER_LAST);
    endfunction

    // low TOT_W bits of a count, zero-extended first for small depths
    function automatic logic [TOT_W-1:0] to_total(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+TOT_W-1:0] wide;
        wide = {{TOT_W{1'b0}}, cnt};
        return wide[TOT_W-1:0];
    endfunction

endpackage

FILE: rtl/core/cdq_ring.sv
module cdq_ring (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  cdq_pkg::t_req              i_req,
    output cdq_pkg::t_ring_res         o_res,
    output logic [cdq_pkg::CHAR_W-1:0] o_rd_data
);

    logic [cdq_pkg::CHAR_W-1:0] mem [cdq_pkg::DEPTH];

    logic [cdq_pkg::ADDR_W-1:0] r_head, n_head;
    logic [cdq_pkg::CNT_W-1:0]  r_fill, n_fill;
    cdq_pkg::t_ring_res         r_res, n_res;
    logic [cdq_pkg::CHAR_W-1:0] r_rd;

    logic [cdq_pkg::ADDR_W-1:0] w_addr;
    logic                       w_wr, w_rd;
    logic [cdq_pkg::ADDR_W-1:0] w_head_dec, w_head_inc, w_back, w_last;
    logic [cdq_pkg::SUM_W-1:0]  w_sum, w_sum_m1, w_back_w, w_last_w;
    logic                       w_full, w_empty;

    assign w_full  = (r_fill == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
    assign w_empty = (r_fill == '0);

    assign w_head_dec = (r_head == '0) ? cdq_pkg::ADDR_W'(cdq_pkg::DEPTH - 1)
                                       : r_head - 1'b1;
    assign w_head_inc = (r_head == cdq_pkg::ADDR_W'(cdq_pkg::DEPTH - 1)) ? '0
                                       : r_head + 1'b1;

    // head + fill stays below 2*DEPTH: one compare and subtract wraps it
    assign w_sum    = cdq_pkg::SUM_W'(r_head) + cdq_pkg::SUM_W'(r_fill);
    assign w_sum_m1 = w_sum - 1'b1;
    assign w_back_w = (w_sum >= cdq_pkg::SUM_W'(cdq_pkg::DEPTH))
                    ? w_sum - cdq_pkg::SUM_W'(cdq_pkg::DEPTH) : w_sum;
    assign w_last_w = (w_sum_m1 >= cdq_pkg::SUM_W'(cdq_pkg::DEPTH))
                    ? w_sum_m1 - cdq_pkg::SUM_W'(cdq_pkg::DEPTH) : w_sum_m1;
    assign w_back   = w_back_w[cdq_pkg::ADDR_W-1:0];
    assign w_last   = w_last_w[cdq_pkg::ADDR_W-1:0];

    always_comb begin
        n_head      = r_head;
        n_fill      = r_fill;
        w_addr      = r_head;
        w_wr        = 1'b0;
        w_rd        = 1'b0;
        n_res       = '0;
        n_res.vld   = i_req.vld;
        n_res.chr   = i_req.chr;
        if (i_req.vld) begin
            unique case (i_req.op)
                cdq_pkg::OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_res.full = 1'b1;
                    end else begin
                        w_addr        = w_head_dec;
                        n_head        = w_head_dec;
                        n_fill        = r_fill + 1'b1;
                        w_wr          = 1'b1;
                        n_res.push_ok = 1'b1;
                    end
                end
                cdq_pkg::OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_res.full = 1'b1;
                    end else begin
                        w_addr        = w_back;
                        n_fill        = r_fill + 1'b1;
                        w_wr          = 1'b1;
                        n_res.push_ok = 1'b1;
                    end
                end
                cdq_pkg::OP_POP_FRONT: begin
                    if (w_empty) begin
                        n_res.empty = 1'b1;
                    end else begin
                        w_addr       = r_head;
                        n_head       = w_head_inc;
                        n_fill       = r_fill - 1'b1;
                        w_rd         = 1'b1;
                        n_res.pop_ok = 1'b1;
                    end
                end
                cdq_pkg::OP_POP_BACK: begin
                    if (w_empty) begin
                        n_res.empty = 1'b1;
                    end else begin
                        w_addr       = w_last;
                        n_fill       = r_fill - 1'b1;
                        w_rd         = 1'b1;
                        n_res.pop_ok = 1'b1;
                    end
                end
                default: ;  // report and unused codes leave the ring alone
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_fill    <= '0;
            r_res.vld <= 1'b0;
        end else if (i_en) begin
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_res.vld <= n_res.vld;
        end
        if (i_en) begin
            r_res.push_ok <= n_res.push_ok;
            r_res.pop_ok  <= n_res.pop_ok;
            r_res.empty   <= n_res.empty;
            r_res.full    <= n_res.full;
            r_res.chr     <= n_res.chr;
        end
    end

    // single-port store: one write or one registered read per enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en && w_wr) begin
            mem[w_addr] <= i_req.chr;
        end
        if (i_en && w_rd) begin
            r_rd <= mem[w_addr];
        end
    end

    assign o_res     = r_res;
    assign o_rd_data = r_rd;

endmodule

FILE: rtl/core/char_deque_with_case_count_top.sv
// A request accepted into the input register passes the ring-step register, then the result register.
// Throughput: one request per cycle while the result is taken; the store's single port and its read register
//   set the depth of the three-stage pipe (input, ring step, result).
// Reset (synchronous, i_rst_n low): pointers, fill level, letter counts and all
//   valid flags clear; the character store itself is not cleared.
`include "assert_macros.svh"

module char_deque_with_case_count_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [2:0] op, [10:3] char_in, [15:11] zero
    // result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // [7:0] char_out, [8] was_empty, [9] was_full,
                                         // [16:10] lower_total, [23:17] upper_total
);

    // Whole pipe moves together; it stops only while a finished result waits.
    logic w_en;

    cdq_pkg::t_req              r_s1;
    cdq_pkg::t_ring_res         w_res;
    logic [cdq_pkg::CHAR_W-1:0] w_rd_data;

    // result register
    logic                       r_out_vld;
    logic [cdq_pkg::CHAR_W-1:0] r_out_chr, n_out_chr;
    logic                       r_out_empty, r_out_full;

    // letters currently held; updated as each request leaves the ring stage
    logic [cdq_pkg::CNT_W-1:0]  r_lower, n_lower;
    logic [cdq_pkg::CNT_W-1:0]  r_upper, n_upper;
    logic [cdq_pkg::CNT_W:0]    w_held_sum;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (w_en) begin
            r_s1.vld <= i_s_axis_tvalid;
        end
        if (w_en) begin
            r_s1.op  <= cdq_pkg::t_op'(i_s_axis_tdata[cdq_pkg::OP_W-1:0]);
            r_s1.chr <= i_s_axis_tdata[cdq_pkg::OP_W +: cdq_pkg::CHAR_W];
        end
    end

    // stage 2: pointer update and store access
    cdq_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_req     (r_s1),
        .o_res     (w_res),
        .o_rd_data (w_rd_data)
    );

    // stage 3: letter counts follow the pushed or popped byte
    always_comb begin
        n_lower   = r_lower;
        n_upper   = r_upper;
        n_out_chr = '0;
        if (w_res.vld && w_res.push_ok) begin
            if (cdq_pkg::is_lower(w_res.chr)) begin
                n_lower = r_lower + 1'b1;
            end else if (cdq_pkg::is_upper(w_res.chr)) begin
                n_upper = r_upper + 1'b1;
            end
        end else if (w_res.vld && w_res.pop_ok) begin
            n_out_chr = w_rd_data;
            if (cdq_pkg::is_lower(w_rd_data) && (r_lower != '0)) begin
                n_lower = r_lower - 1'b1;
            end else if (cdq_pkg::is_upper(w_rd_data) && (r_upper != '0)) begin
                n_upper = r_upper - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_lower   <= '0;
            r_upper   <= '0;
        end else if (w_en) begin
            r_out_vld <= w_res.vld;
            r_lower   <= n_lower;
            r_upper   <= n_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_chr   <= n_out_chr;
            r_out_empty <= w_res.empty;
            r_out_full  <= w_res.full;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {cdq_pkg::to_total(r_upper),
                              cdq_pkg::to_total(r_lower),
                              r_out_full,
                              r_out_empty,
                              r_out_chr};

    assign w_held_sum = (cdq_pkg::CNT_W + 1)'(r_lower) + (cdq_pkg::CNT_W + 1)'(r_upper);

    // a request is never both refused as full and found empty
    `ASSERT_IMP(a_flags_excl, r_out_vld, !(r_out_empty && r_out_full))
    // an empty pop returns a zero byte
    `ASSERT_IMP(a_empty_zero, r_out_vld && r_out_empty, r_out_chr == '0)
    // letters held never exceed the store size
    `ASSERT_IMP(a_held_bound, 1'b1, w_held_sum <= (cdq_pkg::CNT_W + 1)'(cdq_pkg::DEPTH))
    // a refused pop, when the pipe moves, shows as a valid empty result in the next cycle
    `ASSERT_NXT(a_empty_next, w_en && w_res.vld && w_res.empty, r_out_vld && r_out_empty)

endmodule
